// ===== sv/isc_pkg.sv =====
// Shared types and constants for the integer stack calculator.
// Used by the controller, the datapath and the top level.
package isc_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned LIM_W  = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH     = 3'd0,
    REQ_POP      = 3'd1,
    REQ_ADD      = 3'd2,
    REQ_SUB      = 3'd3,
    REQ_MULT     = 3'd4,
    REQ_DIV      = 3'd5,
    REQ_ADD_ALL  = 3'd6,
    REQ_MULT_ALL = 3'd7
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_FEW  = 2'd2,
    ST_DIVZ = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // clear multiplier partial product and step counter
    logic rd_top;     // select subtraction in fin_alu
    logic cap_a;      // capture read data into operand a
    logic cap_b;      // capture read data into operand b
    logic fold_init;  // set accumulator to fold start value
    logic fold_step;  // fold read data into accumulator
    logic mul_step;   // one shift-add step of the multiplier
    logic div_init;   // start division from operand a and read data
    logic div_step;   // one restoring step
    logic fin_div;    // apply quotient sign
    logic fin_alu;    // compute add/sub result, or copy product, into accumulator
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic step_last;  // counter at final step
  } sts_t;

endpackage

// ===== sv/integer_stack_calculator.sv =====
// Integer stack calculator top level: controller, datapath, limit register.
// Mult and div run 32 steps of the shared shift-add/restoring unit; folds read
// each stored entry in turn. Push and refusals take a word every cycle while the
// output is not stalled; other requests hold the input until they are done.
// One word at a time.
// Synchronous active-low reset empties the stack and sets the limit to 16.
module integer_stack_calculator import isc_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [LIM_W-1:0]  cfg_stack_limit,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [WORD_W-1:0] in_operand_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_result_value,
  output logic [ST_W-1:0]   out_status,
  output logic [LIM_W-1:0]  out_depth
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [LIM_W-1:0]  limit_r;
  cmd_t              cmd;
  sts_t              sts;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              wr_en, is_mult;
  logic [WORD_W-1:0] wr_data, rd_data, acc;

  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= LIM_W'(16);
    else if (cfg_we) limit_r <= cfg_stack_limit;
  end

  isc_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_req_type, .in_operand_value,
    .out_valid, .out_stall, .out_result_value, .out_status, .out_depth,
    .cap(limit_r), .rd_data, .acc, .sts, .cmd, .rd_addr,
    .wr_en, .wr_addr, .wr_data, .is_mult
  );

  isc_datapath #(.DEPTH(DEPTH), .AW(AW)) u_dp (
    .clk, .cmd, .rd_addr, .wr_en, .wr_addr, .wr_data, .is_mult,
    .rd_data, .acc, .sts
  );

endmodule

// ===== sv/isc_datapath.sv =====
// Datapath: stack memory, operand registers, shift-add multiplier and
// restoring divider sharing one step counter. Depends on isc_pkg.
module isc_datapath import isc_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic              clk,
  input  cmd_t              cmd,
  input  logic [AW-1:0]     rd_addr,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic              is_mult,
  output logic [WORD_W-1:0] rd_data,
  output logic [WORD_W-1:0] acc,
  output sts_t              sts
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_r;
  logic [WORD_W-1:0] a_r, b_r, acc_r, rem_r;
  logic [5:0]        step_r;
  logic              qneg_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   rem_sub;
  logic [WORD_W-1:0] fold_mul;

  assign rem_sh  = {rem_r, acc_r[WORD_W-1]};
  assign rem_sub = rem_sh - {1'b0, b_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r  <= '0;
      step_r <= '0;
    end
    if (cmd.cap_a) a_r <= rd_r;
    if (cmd.cap_b) b_r <= rd_r;
    if (cmd.fold_init) acc_r <= is_mult ? WORD_W'(1) : '0;
    if (cmd.fold_step) acc_r <= is_mult ? (acc_r * rd_r) : (acc_r + rd_r);
    if (cmd.mul_step) begin
      if (b_r[0]) rem_r <= rem_r + a_r;
      a_r    <= a_r << 1;
      b_r    <= b_r >> 1;
      step_r <= step_r + 6'd1;
    end
    if (cmd.div_init) begin
      qneg_r <= a_r[WORD_W-1] ^ rd_r[WORD_W-1];
      acc_r  <= rd_r[WORD_W-1] ? -rd_r : rd_r;
      b_r    <= a_r[WORD_W-1] ? -a_r : a_r;
      rem_r  <= '0;
      step_r <= '0;
    end
    if (cmd.div_step) begin
      if (!rem_sub[WORD_W]) begin
        rem_r <= rem_sub[WORD_W-1:0];
        acc_r <= {acc_r[WORD_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[WORD_W-1:0];
        acc_r <= {acc_r[WORD_W-2:0], 1'b0};
      end
      step_r <= step_r + 6'd1;
    end
    if (cmd.fin_div && qneg_r) acc_r <= -acc_r;
    if (cmd.fin_alu) acc_r <= fold_mul;
  end

  // fin_alu: add/sub result, or copy product out of rem
  always_comb begin
    fold_mul = rem_r;
    if (!is_mult) fold_mul = cmd.rd_top ? (a_r - b_r) : (a_r + b_r);
  end

  assign rd_data       = rd_r;
  assign acc           = acc_r;
  assign sts.step_last = (step_r == 6'd31);

endmodule

// ===== sv/isc_ctrl.sv =====
// Controller: sequences one request through reads, arithmetic steps and
// write-back, and drives the handshake. Depends on isc_pkg.
module isc_ctrl import isc_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [WORD_W-1:0] in_operand_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_result_value,
  output logic [ST_W-1:0]   out_status,
  output logic [LIM_W-1:0]  out_depth,
  input  logic [LIM_W-1:0]  cap,
  input  logic [WORD_W-1:0] rd_data,
  input  logic [WORD_W-1:0] acc,
  input  sts_t              sts,
  output cmd_t              cmd,
  output logic [AW-1:0]     rd_addr,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [WORD_W-1:0] wr_data,
  output logic              is_mult
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_RD1   = 11'b00000000010,
    S_RD2   = 11'b00000000100,
    S_CAPB  = 11'b00000001000,
    S_MUL   = 11'b00000010000,
    S_DIV   = 11'b00000100000,
    S_FIN   = 11'b00001000000,
    S_FRD   = 11'b00010000000,
    S_FSTEP = 11'b00100000000,
    S_WB    = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [AW:0]        count_r, count_nxt;
  logic [REQ_W-1:0]   req_r;
  logic               ovalid_r, ovalid_nxt;
  logic [WORD_W-1:0]  ores_r, ores_nxt;
  logic [ST_W-1:0]    ost_r, ost_nxt;
  logic [AW:0]        fidx_r, fidx_nxt;

  logic               take;
  logic               out_free;
  logic               divz_nxt;
  logic [AW:0]        capc;

  assign capc     = (32'(cap) > DEPTH) ? (AW+1)'(DEPTH) : (AW+1)'(cap);
  assign out_free = !ovalid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign take     = in_valid && !in_stall;
  assign is_mult  = (state_r == S_IDLE) ? (in_req_type == REQ_MULT_ALL) :
                    ((req_r == REQ_MULT) || (req_r == REQ_MULT_ALL));

  // Division by zero is found when the top entry is read
  assign divz_nxt = (state_r == S_RD2) && (req_r == REQ_DIV) && (rd_data == '0);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ovalid_nxt = ovalid_r && out_stall;
    ores_nxt   = ores_r;
    ost_nxt    = ost_r;
    fidx_nxt   = fidx_r;
    cmd        = '0;
    cmd.load   = take;
    rd_addr    = count_r[AW-1:0] - AW'(1);
    wr_en      = 1'b0;
    wr_addr    = count_r[AW-1:0];
    wr_data    = in_operand_value;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          ost_nxt  = ST_OK;
          ores_nxt = '0;
          unique case (req_t'(in_req_type))
            REQ_PUSH: begin
              if (count_r >= capc) begin
                ost_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                ores_nxt  = in_operand_value;
                count_nxt = count_r + (AW+1)'(1);
              end
              ovalid_nxt = 1'b1;
            end
            REQ_POP, REQ_ADD, REQ_SUB, REQ_MULT, REQ_DIV: begin
              if ((in_req_type == REQ_POP && count_r == '0) ||
                  (in_req_type != REQ_POP && count_r < (AW+1)'(2))) begin
                ost_nxt    = ST_FEW;
                ovalid_nxt = 1'b1;
              end else begin
                state_nxt = S_RD1;
              end
            end
            REQ_ADD_ALL, REQ_MULT_ALL: begin
              if (capc == '0) begin
                ost_nxt    = ST_FULL;
                ovalid_nxt = 1'b1;
              end else begin
                fidx_nxt      = '0;
                cmd.fold_init = 1'b1;
                state_nxt     = (count_r == '0) ? S_WB : S_FRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD1: begin
        // top entry read issued here, second next cycle
        rd_addr   = count_r[AW-1:0] - AW'(1);
        state_nxt = S_RD2;
      end
      S_RD2: begin
        rd_addr = count_r[AW-1:0] - AW'(2);
        if (req_r == REQ_POP) begin
          ores_nxt   = rd_data;
          count_nxt  = count_r - (AW+1)'(1);
          ovalid_nxt = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          cmd.cap_a = 1'b1;
          state_nxt = S_CAPB;
        end
      end
      S_CAPB: begin
        unique case (req_t'(req_r))
          REQ_ADD, REQ_SUB: begin
            cmd.cap_b = 1'b1;
            state_nxt = S_FIN;
          end
          REQ_MULT: begin
            cmd.cap_b = 1'b1;
            state_nxt = S_MUL;
          end
          default: begin
            cmd.div_init = 1'b1;
            state_nxt    = S_DIV;
          end
        endcase
      end
      S_MUL: begin
        // a = top, b = second; product builds in the remainder register
        cmd.mul_step = 1'b1;
        if (sts.step_last) state_nxt = S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.step_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (req_r == REQ_DIV) cmd.fin_div = 1'b1;
        else begin
          cmd.fin_alu = 1'b1;
          cmd.rd_top  = (req_r == REQ_SUB);
        end
        state_nxt = S_WB;
      end
      S_FRD: begin
        rd_addr   = fidx_r[AW-1:0];
        state_nxt = S_FSTEP;
      end
      S_FSTEP: begin
        cmd.fold_step = 1'b1;
        fidx_nxt      = fidx_r + (AW+1)'(1);
        if (fidx_r + (AW+1)'(1) >= count_r) state_nxt = S_WB;
        else state_nxt = S_FRD;
      end
      S_WB: begin
        wr_en = 1'b1;
        if (req_r == REQ_ADD_ALL || req_r == REQ_MULT_ALL) begin
          wr_addr    = '0;
          wr_data    = acc;
          ores_nxt   = acc;
          count_nxt  = (AW+1)'(1);
          ovalid_nxt = 1'b1;
        end else if (req_r == REQ_DIV && ost_r == ST_DIVZ) begin
          wr_en      = 1'b0;
          ovalid_nxt = 1'b1;
        end else begin
          wr_addr    = count_r[AW-1:0] - AW'(2);
          wr_data    = acc;
          ores_nxt   = acc;
          count_nxt  = count_r - (AW+1)'(1);
          ovalid_nxt = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // S_OUT lets the registered output become visible first and holds while it is stalled
    if (state_r == S_OUT && ovalid_r && out_stall) state_nxt = S_OUT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= (divz_nxt) ? S_WB : state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
    if (take) req_r <= in_req_type;
    ores_r <= ores_nxt;
    ost_r  <= divz_nxt ? ST_DIVZ : ost_nxt;
    fidx_r <= fidx_nxt;
  end

  assign out_valid        = ovalid_r;
  assign out_result_value = ores_r;
  assign out_status       = ost_r;
  assign out_depth        = LIM_W'(count_r);

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the integer stack calculator.
// Drives request words, predicts each result from its own stack model and
// compares status, value and depth. Depends on isc_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb;
  import isc_pkg::*;

  typedef struct {
    logic [WORD_W-1:0] value;
    status_t           status;
    logic [LIM_W-1:0]  depth;
  } calc_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [LIM_W-1:0]  cfg_stack_limit = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [REQ_W-1:0]  in_req_type = '0;
  logic [WORD_W-1:0] in_operand_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] out_result_value;
  logic [ST_W-1:0]   out_status;
  logic [LIM_W-1:0]  out_depth;

  logic [WORD_W-1:0] model_stack [16];
  int unsigned       model_count;
  int unsigned       model_limit;
  calc_result_t      expected_results[$];
  int unsigned       mismatches;
  int unsigned       words_sent;
  int unsigned       words_checked;
  int unsigned       stall_left;
  bit                sender_idle_on;
  bit                receiver_idle_on;

  integer_stack_calculator #(.DEPTH(16)) dut (.*);

  always #5 clk = ~clk;

  initial begin
    #50ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [WORD_W-1:0] quotient_of(logic [WORD_W-1:0] num,
                                                    logic [WORD_W-1:0] den);
    logic [WORD_W-1:0] nm;
    logic [WORD_W-1:0] dm;
    logic [WORD_W-1:0] q;
    nm = num[31] ? -num : num;
    dm = den[31] ? -den : den;
    q = nm / dm;
    return (num[31] != den[31]) ? -q : q;
  endfunction

  function automatic calc_result_t calculate(req_t req, logic [WORD_W-1:0] val);
    calc_result_t r;
    int unsigned cap;
    logic [WORD_W-1:0] t;
    logic [WORD_W-1:0] s;
    logic [WORD_W-1:0] acc;
    r.value = '0;
    r.status = ST_OK;
    cap = (model_limit > 16) ? 16 : model_limit;
    case (req)
      REQ_PUSH: begin
        if (model_count >= cap) r.status = ST_FULL;
        else begin
          model_stack[model_count] = val;
          model_count++;
          r.value = val;
        end
      end
      REQ_POP: begin
        if (model_count == 0) r.status = ST_FEW;
        else begin
          model_count--;
          r.value = model_stack[model_count];
        end
      end
      REQ_ADD_ALL, REQ_MULT_ALL: begin
        if (cap == 0) r.status = ST_FULL;
        else begin
          acc = (req == REQ_ADD_ALL) ? 32'd0 : 32'd1;
          for (int i = 0; i < model_count; i++)
            acc = (req == REQ_ADD_ALL) ? acc + model_stack[i] : acc * model_stack[i];
          model_stack[0] = acc;
          model_count = 1;
          r.value = acc;
        end
      end
      default: begin
        if (model_count < 2) r.status = ST_FEW;
        else begin
          t = model_stack[model_count-1];
          s = model_stack[model_count-2];
          if (req == REQ_DIV && t == '0) r.status = ST_DIVZ;
          else begin
            case (req)
              REQ_ADD:  r.value = t + s;
              REQ_SUB:  r.value = t - s;
              REQ_MULT: r.value = t * s;
              default:  r.value = quotient_of(s, t);
            endcase
            model_stack[model_count-2] = r.value;
            model_count--;
          end
        end
      end
    endcase
    r.depth = model_count[LIM_W-1:0];
    return r;
  endfunction

  task automatic send_word(req_t req, logic [WORD_W-1:0] val);
    int gap;
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_operand_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(calculate(req, val));
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_limit(int unsigned lim);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_stack_limit <= lim[LIM_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    model_limit = lim;
  endtask

  function automatic logic [WORD_W-1:0] random_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 4);
      3: return -$urandom_range(1, 4);
      default: return $urandom;
    endcase
  endfunction

  // result checker and random output stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (stall_left != 0) begin
        stall_left--;
        if (stall_left == 0) out_stall <= 1'b0;
      end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(1, 10);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word value=%h", out_result_value);
        end else begin
          calc_result_t e;
          e = expected_results.pop_front();
          words_checked++;
          if (e.value !== out_result_value || e.status !== out_status ||
              e.depth !== out_depth) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp value=%h status=%0d depth=%0d got %h %0d %0d",
                       e.value, e.status, e.depth, out_result_value, out_status,
                       out_depth);
          end
        end
      end
    end
  end

  task automatic test_directed();
    send_word(REQ_POP, 0);
    send_word(REQ_ADD, 0);
    send_word(REQ_PUSH, 32'h7FFF_FFFF);
    send_word(REQ_DIV, 0);
    send_word(REQ_PUSH, 32'h8000_0000);
    send_word(REQ_ADD, 0);
    send_word(REQ_PUSH, 32'hFFFF_FFFF);
    send_word(REQ_PUSH, 32'h8000_0000);
    send_word(REQ_PUSH, 32'hFFFF_FFFF);
    send_word(REQ_DIV, 0);
    send_word(REQ_PUSH, 0);
    send_word(REQ_DIV, 0);
    send_word(REQ_SUB, 0);
    send_word(REQ_PUSH, 32'd7);
    send_word(REQ_PUSH, -32'd2);
    send_word(REQ_DIV, 0);
    send_word(REQ_MULT, 0);
    send_word(REQ_MULT_ALL, 0);
    send_word(REQ_POP, 0);
    send_word(REQ_ADD_ALL, 0);
    send_word(REQ_POP, 0);
    send_word(REQ_MULT_ALL, 0);
  endtask

  task automatic test_capacity(int unsigned lim);
    write_limit(lim);
    for (int i = 0; i < 18; i++) send_word(REQ_PUSH, $urandom);
    send_word(REQ_ADD_ALL, 0);
    for (int i = 0; i < 2; i++) send_word(REQ_POP, 0);
  endtask

  task automatic test_random(int n);
    req_t r;
    for (int i = 0; i < n; i++) begin
      if (model_count < 3 || $urandom_range(0, 2) == 0) r = REQ_PUSH;
      else r = req_t'($urandom_range(0, 7));
      send_word(r, random_value());
    end
  endtask

  initial begin
    model_count = 0;
    model_limit = 16;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sender_idle_on = 1;
    receiver_idle_on = 1;
    test_directed();
    test_capacity(0);
    test_capacity(1);
    test_capacity(31);
    write_limit(5);
    test_random(150);
    write_limit(2);
    test_random(100);
    write_limit(16);
    test_random(300);
    wait_drained();
    write_limit(0);
    test_random(40);
    write_limit(16);
    sender_idle_on = 0;
    receiver_idle_on = 0;
    test_random(250);
    wait_drained();
    $display("sent %0d request words, checked %0d results, limits 0 to 31",
             words_sent, words_checked);
    if (mismatches == 0) $display("*** PASSED ***");
    else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/isc_pkg.sv
sv/isc_datapath.sv
sv/isc_ctrl.sv
sv/integer_stack_calculator.sv
sim/tb.sv
